[design/round_robin_task_table_mailboxes_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the task table block
// Shared helpers for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_TABLE_MAILBOXES_DEFINES_SVH
`define ROUND_ROBIN_TASK_TABLE_MAILBOXES_DEFINES_SVH

// implication check, disabled in reset
`define RRTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication check
`define RRTT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

[design/rrtt_pkg.sv]
// ----------------------------------------------------------------------------
// rrtt_pkg
// Types and constants shared by the task table block.
// ----------------------------------------------------------------------------
package rrtt_pkg;

    localparam int TASK_SLOTS_DEF = 16;
    localparam int RING_DEPTH_DEF = 32;
    localparam int EVENT_BITS_DEF = 64;
    localparam int IDENT_BITS_DEF = 16;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;
    localparam int TID_W    = 16;
    localparam int EXIT_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int LIVE_W   = 5;
    localparam int EV_W     = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_SPAWN = 3'd0,
        CMD_YIELD = 3'd1,
        CMD_EXIT  = 3'd2,
        CMD_POST  = 3'd3,
        CMD_GET   = 3'd4,
        CMD_JOIN  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_RUNNING   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_RDWAIT,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request, clear scan
        logic scan;     // examine one slot
        logic act;      // apply the command
        logic rd_take;  // capture ring read data
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic rd_pending;
    } stat_t;

endpackage

[design/rrtt_if.sv]
// ----------------------------------------------------------------------------
// rrtt_req_if / rrtt_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface rrtt_req_if;
    logic                    valid;
    logic                    ready;
    logic [2:0]              cmd;
    logic [15:0]             target_id;
    logic [63:0]             event_payload;
    logic signed [31:0]      exit_value;
    modport source (output valid, cmd, target_id, event_payload, exit_value, input ready);
    modport sink   (input valid, cmd, target_id, event_payload, exit_value, output ready);
endinterface

interface rrtt_rsp_if;
    logic                    valid;
    logic                    ready;
    logic [2:0]              status;
    logic [15:0]             task_ident;
    logic [3:0]              current_slot;
    logic [63:0]             event_out;
    logic signed [31:0]      exit_result;
    logic [4:0]              live_count;
    modport source (output valid, status, task_ident, current_slot, event_out, exit_result,
                    live_count, input ready);
    modport sink   (input valid, status, task_ident, current_slot, event_out, exit_result,
                    live_count, output ready);
endinterface

[design/rrtt_ram.sv]
// ----------------------------------------------------------------------------
// rrtt_ram
// Single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrtt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/rrtt_ctrl.sv]
// ----------------------------------------------------------------------------
// rrtt_ctrl
// Command sequencer: load, slot scan, apply, optional ring read, deliver.
// ----------------------------------------------------------------------------
module rrtt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  rrtt_pkg::stat_t st,
    output rrtt_pkg::ctrl_t ctl
);
    import rrtt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_SCAN;
            S_SCAN:   if (st.scan_done) state_next = S_ACT;
            S_ACT:    state_next = st.rd_pending ? S_RDWAIT : S_DONE;
            S_RDWAIT: state_next = S_DONE;
            S_DONE:   if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            S_SCAN:   ctl.scan = 1'b1;
            S_ACT:    ctl.act = 1'b1;
            S_RDWAIT: ctl.rd_take = 1'b1;
            S_DONE:   out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

[design/rrtt_dp.sv]
// ----------------------------------------------------------------------------
// rrtt_dp
// Task table datapath: slot registers, ring pointers, event RAM, slot scan.
// ----------------------------------------------------------------------------
module rrtt_dp #(
    parameter int TASK_SLOTS = rrtt_pkg::TASK_SLOTS_DEF,
    parameter int RING_DEPTH = rrtt_pkg::RING_DEPTH_DEF,
    parameter int EVENT_BITS = rrtt_pkg::EVENT_BITS_DEF,
    parameter int IDENT_BITS = rrtt_pkg::IDENT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rrtt_pkg::ctrl_t                  ctl,
    output rrtt_pkg::stat_t                  st,
    input  logic [rrtt_pkg::CMD_W-1:0]       cmd,
    input  logic [rrtt_pkg::TID_W-1:0]       target_id,
    input  logic [rrtt_pkg::EV_W-1:0]        event_payload,
    input  logic [rrtt_pkg::EXIT_W-1:0]      exit_value,
    output logic [rrtt_pkg::STATUS_W-1:0]    status,
    output logic [rrtt_pkg::TID_W-1:0]       task_ident,
    output logic [rrtt_pkg::SLOT_W-1:0]      current_slot,
    output logic [rrtt_pkg::EV_W-1:0]        event_out,
    output logic [rrtt_pkg::EXIT_W-1:0]      exit_result,
    output logic [rrtt_pkg::LIVE_W-1:0]      live_count
);
    import rrtt_pkg::*;

    localparam int SW  = $clog2(TASK_SLOTS);
    localparam int PW  = $clog2(RING_DEPTH);
    localparam int CW  = $clog2(TASK_SLOTS + 1);
    localparam int TID_USE = (IDENT_BITS < TID_W) ? IDENT_BITS : TID_W;
    localparam int EV_USE  = (EVENT_BITS < EV_W) ? EVENT_BITS : EV_W;

    // slot table
    logic [TASK_SLOTS-1:0] used_reg;
    logic [IDENT_BITS-1:0] ident_reg [TASK_SLOTS];
    logic [EXIT_W-1:0]     exitc_reg [TASK_SLOTS];
    logic [PW-1:0]         wptr_reg  [TASK_SLOTS];
    logic [PW-1:0]         rptr_reg  [TASK_SLOTS];
    logic [SW-1:0]         run_reg;
    logic [IDENT_BITS-1:0] nid_reg;
    logic [CW-1:0]         live_reg;

    // captured request
    logic [CMD_W-1:0]      cmd_reg;
    logic [IDENT_BITS-1:0] tgt_reg;
    logic [EVENT_BITS-1:0] pay_reg;
    logic [EXIT_W-1:0]     xval_reg;

    // scan state
    logic [SW:0]           idx_reg;
    logic                  free_hit_reg, post_hit_reg, join_hit_reg, rr_hit_reg;
    logic [SW-1:0]         free_slot_reg, post_slot_reg, join_slot_reg, rr_slot_reg;
    logic [SW-1:0]         rr_base_reg;

    // result
    logic [STATUS_W-1:0]   status_reg;
    logic [TID_W-1:0]      tident_reg;
    logic [EV_W-1:0]       evout_reg;
    logic [EXIT_W-1:0]     xres_reg;

    logic [SW-1:0]         idx;
    logic [SW-1:0]         rr_idx;
    logic [SW:0]           rr_sum;
    logic                  rr_used;

    logic                     ram_we;
    logic [SW+PW-1:0]         ram_waddr, ram_raddr;
    logic [EVENT_BITS-1:0]    ram_rdata;
    logic [PW-1:0]            post_nxt;

    assign idx    = idx_reg[SW-1:0];
    assign rr_sum = {1'b0, rr_base_reg} + {1'b0, idx} + {{SW{1'b0}}, 1'b1};
    assign rr_idx = (rr_sum >= (SW+1)'(TASK_SLOTS)) ? SW'(rr_sum - (SW+1)'(TASK_SLOTS))
                                                    : rr_sum[SW-1:0];
    // slot being exited counts as free during the round-robin scan
    assign rr_used = used_reg[rr_idx] &&
                     !(cmd_reg == CMD_EXIT && rr_idx == run_reg && run_reg != '0);

    assign st.scan_done  = (idx_reg == (SW+1)'(TASK_SLOTS - 1));
    // get on a non-empty ring needs the RAM read cycle
    assign st.rd_pending = cmd_reg == CMD_GET && wptr_reg[run_reg] != rptr_reg[run_reg];

    assign post_nxt  = (wptr_reg[post_slot_reg] == PW'(RING_DEPTH - 1)) ? '0
                       : wptr_reg[post_slot_reg] + 1'b1;
    assign ram_we    = ctl.act && cmd_reg == CMD_POST && post_hit_reg &&
                       post_nxt != rptr_reg[post_slot_reg];
    assign ram_waddr = {post_slot_reg, wptr_reg[post_slot_reg]};
    assign ram_raddr = {run_reg, rptr_reg[run_reg]};

    rrtt_ram #(
        .WIDTH (EVENT_BITS),
        .DEPTH (TASK_SLOTS * RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pay_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd;
            tgt_reg  <= IDENT_BITS'(target_id[TID_USE-1:0]);
            pay_reg  <= EVENT_BITS'(event_payload[EV_USE-1:0]);
            xval_reg <= exit_value;
            rr_base_reg <= run_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= TASK_SLOTS'(1);
            run_reg      <= '0;
            nid_reg      <= IDENT_BITS'(1);
            live_reg     <= CW'(1);
            idx_reg      <= '0;
            free_hit_reg <= 1'b0;
            post_hit_reg <= 1'b0;
            join_hit_reg <= 1'b0;
            rr_hit_reg   <= 1'b0;
            status_reg   <= '0;
            tident_reg   <= '0;
            evout_reg    <= '0;
            xres_reg     <= '0;
            free_slot_reg <= '0;
            post_slot_reg <= '0;
            join_slot_reg <= '0;
            rr_slot_reg   <= '0;
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                ident_reg[i] <= '0;
                exitc_reg[i] <= '0;
                wptr_reg[i]  <= '0;
                rptr_reg[i]  <= '0;
            end
        end
        else
        begin
            if (ctl.load)
            begin
                idx_reg      <= '0;
                free_hit_reg <= 1'b0;
                post_hit_reg <= 1'b0;
                join_hit_reg <= 1'b0;
                rr_hit_reg   <= 1'b0;
            end
            if (ctl.scan)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (!free_hit_reg && idx != '0 && !used_reg[idx])
                begin
                    free_hit_reg  <= 1'b1;
                    free_slot_reg <= idx;
                end
                if (!post_hit_reg && used_reg[idx] && ident_reg[idx] == tgt_reg)
                begin
                    post_hit_reg  <= 1'b1;
                    post_slot_reg <= idx;
                end
                if (!join_hit_reg && ident_reg[idx] == tgt_reg)
                begin
                    join_hit_reg  <= 1'b1;
                    join_slot_reg <= idx;
                end
                if (!rr_hit_reg && rr_used)
                begin
                    rr_hit_reg  <= 1'b1;
                    rr_slot_reg <= rr_idx;
                end
            end
            if (ctl.act)
            begin
                status_reg <= ST_OK;
                evout_reg  <= '0;
                xres_reg   <= '0;
                tident_reg <= TID_W'(ident_reg[run_reg]);
                case (cmd_reg)
                    CMD_SPAWN:
                    begin
                        if (!free_hit_reg)
                        begin
                            status_reg <= ST_FULL;
                        end
                        else
                        begin
                            used_reg[free_slot_reg]  <= 1'b1;
                            ident_reg[free_slot_reg] <= nid_reg;
                            exitc_reg[free_slot_reg] <= '0;
                            wptr_reg[free_slot_reg]  <= '0;
                            rptr_reg[free_slot_reg]  <= '0;
                            nid_reg    <= nid_reg + 1'b1;
                            live_reg   <= live_reg + 1'b1;
                            tident_reg <= TID_W'(nid_reg);
                        end
                    end
                    CMD_YIELD:
                    begin
                        if (rr_hit_reg)
                        begin
                            run_reg    <= rr_slot_reg;
                            tident_reg <= TID_W'(ident_reg[rr_slot_reg]);
                        end
                    end
                    CMD_EXIT:
                    begin
                        if (run_reg != '0)
                        begin
                            exitc_reg[run_reg] <= xval_reg;
                            used_reg[run_reg]  <= 1'b0;
                            live_reg <= live_reg - 1'b1;
                            // slot 0 is always used, so a hit exists
                            run_reg    <= rr_slot_reg;
                            tident_reg <= TID_W'(ident_reg[rr_slot_reg]);
                        end
                    end
                    CMD_POST:
                    begin
                        if (!post_hit_reg)
                        begin
                            status_reg <= ST_NOT_FOUND;
                        end
                        else if (!ram_we)
                        begin
                            status_reg <= ST_FULL;
                        end
                        else
                        begin
                            wptr_reg[post_slot_reg] <= post_nxt;
                        end
                    end
                    CMD_GET:
                    begin
                        if (wptr_reg[run_reg] == rptr_reg[run_reg])
                        begin
                            status_reg <= ST_EMPTY;
                        end
                        else
                        begin
                            rptr_reg[run_reg] <=
                                (rptr_reg[run_reg] == PW'(RING_DEPTH - 1)) ? '0
                                : rptr_reg[run_reg] + 1'b1;
                        end
                    end
                    CMD_JOIN:
                    begin
                        if (!join_hit_reg)
                        begin
                            status_reg <= ST_NOT_FOUND;
                        end
                        else if (used_reg[join_slot_reg])
                        begin
                            status_reg <= ST_RUNNING;
                        end
                        else
                        begin
                            xres_reg <= exitc_reg[join_slot_reg];
                        end
                    end
                    default: ;
                endcase
            end
            if (ctl.rd_take)
            begin
                evout_reg <= EV_W'(ram_rdata);
            end
        end
    end

    assign status       = status_reg;
    assign task_ident   = tident_reg;
    assign current_slot = SLOT_W'(run_reg);
    assign event_out    = evout_reg;
    assign exit_result  = xres_reg;
    assign live_count   = LIVE_W'(live_reg);
endmodule

[design/round_robin_task_table_mailboxes.sv]
// Steps: accept, scan the slots one slot per cycle, apply the command, read the
// ring for a get that pops, then hold the result until it is taken.
// One request in flight: the next is accepted only after the result is taken.
// Reset: rst_n asynchronous active low; slot 0 live, ring pointers cleared,
// next id 1; the event RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// round_robin_task_table_mailboxes
// Task slot table with round-robin yield and one event ring per task.
// ----------------------------------------------------------------------------
module round_robin_task_table_mailboxes #(
    parameter int TASK_SLOTS = rrtt_pkg::TASK_SLOTS_DEF,
    parameter int RING_DEPTH = rrtt_pkg::RING_DEPTH_DEF,
    parameter int EVENT_BITS = rrtt_pkg::EVENT_BITS_DEF,
    parameter int IDENT_BITS = rrtt_pkg::IDENT_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    rrtt_req_if.sink   req,
    rrtt_rsp_if.source rsp
);
    import rrtt_pkg::*;

    ctrl_t ctl;
    stat_t st;

    rrtt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .st        (st),
        .ctl       (ctl)
    );

    rrtt_dp #(
        .TASK_SLOTS (TASK_SLOTS),
        .RING_DEPTH (RING_DEPTH),
        .EVENT_BITS (EVENT_BITS),
        .IDENT_BITS (IDENT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .st            (st),
        .cmd           (req.cmd),
        .target_id     (req.target_id),
        .event_payload (req.event_payload),
        .exit_value    (req.exit_value),
        .status        (rsp.status),
        .task_ident    (rsp.task_ident),
        .current_slot  (rsp.current_slot),
        .event_out     (rsp.event_out),
        .exit_result   (rsp.exit_result),
        .live_count    (rsp.live_count)
    );
endmodule

[design/rrtt_checker.sv]
// ----------------------------------------------------------------------------
// rrtt_checker
// Port-level checks on request/result ordering and result values.
// ----------------------------------------------------------------------------
`include "round_robin_task_table_mailboxes_defines.svh"

module rrtt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  rsp_status,
    input logic [4:0]  rsp_live_count,
    input logic [63:0] rsp_event_out
);
    import rrtt_pkg::*;

    // one request in flight: never ready while a result is shown
    `RRTT_ASSERT_IMP(a_excl, clk, rst_n, rsp_valid, !req_ready)
    // result held until taken
    `RRTT_ASSERT_NXT(a_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    // kernel slot always live
    `RRTT_ASSERT_IMP(a_live, clk, rst_n, rsp_valid, rsp_live_count != 5'd0)
    // no event word unless status ok
    `RRTT_ASSERT_IMP(a_ev, clk, rst_n, rsp_valid && rsp_status != ST_OK, rsp_event_out == '0)
    // accepted request never yields a result in the next cycle
    `RRTT_ASSERT_NXT(a_lat, clk, rst_n, req_valid && req_ready, !rsp_valid)
endmodule

bind round_robin_task_table_mailboxes rrtt_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_live_count (rsp.live_count),
    .rsp_event_out  (rsp.event_out)
);
